FILE: hw/rtl/brma_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Item types, operation and result codes, and the control and status structs
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package brma_pkg;

   // Fixed field widths of the channels.
   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 13;
   localparam int RCNT_W  = 7;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Operation codes of an input item.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE_DONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ_BYTE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ_EMPTY = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAIN_MODE  = 2'd1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data_in;
      logic              first_byte;
      logic [LEN_W-1:0]  message_length;
      logic [RCNT_W-1:0] max_bytes;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_out;
      logic [LEN_W-1:0]  accepted_count;
      logic              last;
      logic [RCNT_W-1:0] removed_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;   // accept the input item and act on it
      logic fetch;  // read the next byte of a read request from the store
      logic send;   // move the fetched byte into the output register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // output register can be loaded this cycle
      logic read_go;   // pending item is a read that removes at least one byte
      logic rd_more;   // further bytes of the current read remain to fetch
   } dp_status_type;

endpackage

FILE: hw/rtl/brma_ctrl.sv
// ----------------------------------------------------------------------------
// Byte ring buffer controller
// Sequences item acceptance and the byte-by-byte streaming of read requests.
// ----------------------------------------------------------------------------
module brma_ctrl
   import brma_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SEND  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               cmd.take = 1'b1;
               if (status.read_go) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.send = 1'b1;
               if (status.rd_more) begin
                  cmd.fetch = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/brma_dpath.sv
// ----------------------------------------------------------------------------
// Byte ring buffer datapath
// Holds the byte store, ring positions, message admission state, the
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module brma_dpath
   import brma_pkg::*;
#(
   parameter int DEPTH    = 4096,
   parameter int MAX_READ = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_payload,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status
);

   localparam int PW  = $clog2(DEPTH);
   localparam int CW0 = $clog2(DEPTH + 1);
   localparam int CW  = (CW0 > LEN_W) ? CW0 : LEN_W;

   // Step a ring position, wrapping at the used size.
   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                             input logic [CW-1:0] s);
      logic [CW:0] nx;
      nx = (CW + 1)'(p) + 1'b1;
      return (nx >= {1'b0, s}) ? '0 : PW'(nx);
   endfunction

   // Storage.
   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   // Configuration.
   logic [CW-1:0] buffer_size_ff;
   logic          drain_mode_ff;

   // Ring and message state.
   logic [PW-1:0]     wr_pos_ff, wr_pos_in;
   logic [PW-1:0]     rd_pos_ff, rd_pos_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic              adm_ff, adm_in;
   logic [PW-1:0]     msg_pos_ff, msg_pos_in;
   logic [RCNT_W-1:0] rd_left_ff, rd_left_in;
   logic [RCNT_W-1:0] rd_total_ff, rd_total_in;

   // Output register.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    out_load;

   // Working values.
   logic [CW-1:0]     size_c;
   logic [CW-1:0]     free_c;
   logic [LEN_W-1:0]  left_e;
   logic [LEN_W-1:0]  total_e;
   logic              adm_e;
   logic [PW-1:0]     pos_e;
   logic              byte_ok;
   logic [LEN_W-1:0]  left_dec;
   logic [PW-1:0]     pos_adv;
   logic [CW:0]       occ_sum;
   logic [CW-1:0]     occ_sat;
   logic [RCNT_W-1:0] max_c;
   logic [RCNT_W-1:0] n_occ;
   logic [CW-1:0]     to_end;
   logic [RCNT_W-1:0] n_c;
   logic              mem_we;
   logic              take_wr;
   logic              take_rd;
   logic              take_clr;

   // Used size: zero acts as one, anything above the store depth as the depth.
   always_comb begin
      if (buffer_size_ff == '0) begin
         size_c = CW'(1);
      end else if (buffer_size_ff > CW'(DEPTH)) begin
         size_c = CW'(DEPTH);
      end else begin
         size_c = buffer_size_ff;
      end
      free_c = (occ_ff >= size_c) ? '0 : size_c - occ_ff;
   end

   // Message admission for a write byte.
   always_comb begin
      if (req_payload.first_byte) begin
         left_e  = req_payload.message_length;
         total_e = req_payload.message_length;
         adm_e   = (free_c >= CW'(req_payload.message_length));
         pos_e   = wr_pos_ff;
         byte_ok = (req_payload.message_length != '0);
      end else begin
         left_e  = left_ff;
         total_e = total_ff;
         adm_e   = adm_ff;
         pos_e   = msg_pos_ff;
         byte_ok = (left_ff != '0);
      end
      left_dec = left_e - 1'b1;
      pos_adv  = advance(pos_e, size_c);
      occ_sum  = {1'b0, occ_ff} + (CW + 1)'(total_e);
      occ_sat  = (occ_sum > (CW + 1)'(DEPTH)) ? CW'(DEPTH) : occ_sum[CW-1:0];
   end

   // Number of bytes a read request removes.
   always_comb begin
      max_c  = (req_payload.max_bytes > RCNT_W'(MAX_READ)) ?
               RCNT_W'(MAX_READ) : req_payload.max_bytes;
      n_occ  = (occ_ff > CW'(max_c)) ? max_c : occ_ff[RCNT_W-1:0];
      to_end = (CW'(rd_pos_ff) < size_c) ? size_c - CW'(rd_pos_ff) : CW'(1);
      n_c    = n_occ;
      if (drain_mode_ff && (n_occ != '0) && (CW'(n_occ) > to_end)) begin
         n_c = to_end[RCNT_W-1:0];
      end
   end

   assign take_wr  = cmd.take && (req_payload.op == OP_WRITE);
   assign take_rd  = cmd.take && (req_payload.op == OP_READ);
   assign take_clr = cmd.take && (req_payload.op == OP_CLEAR);

   // Next state of the ring, the message and the output register.
   always_comb begin
      wr_pos_in   = wr_pos_ff;
      rd_pos_in   = rd_pos_ff;
      occ_in      = occ_ff;
      left_in     = left_ff;
      total_in    = total_ff;
      adm_in      = adm_ff;
      msg_pos_in  = msg_pos_ff;
      rd_left_in  = rd_left_ff;
      rd_total_in = rd_total_ff;
      mem_we      = 1'b0;
      out_load    = 1'b0;
      out_in      = '0;

      if (take_wr) begin
         if (req_payload.first_byte && (req_payload.message_length == '0)) begin
            // An empty message reports nothing admitted at once.
            left_in  = '0;
            adm_in   = 1'b0;
            out_load = 1'b1;
            out_in.kind = KIND_WRITE_DONE;
         end else if (byte_ok) begin
            left_in  = left_dec;
            total_in = total_e;
            adm_in   = adm_e;
            if (adm_e) begin
               mem_we     = 1'b1;
               msg_pos_in = pos_adv;
            end else begin
               msg_pos_in = pos_e;
            end
            // The last byte reports the message and commits it if it was admitted.
            if (left_dec == '0) begin
               adm_in   = 1'b0;
               out_load = 1'b1;
               out_in.kind = KIND_WRITE_DONE;
               if (adm_e) begin
                  out_in.accepted_count = total_e;
                  wr_pos_in = pos_adv;
                  occ_in    = occ_sat;
               end
            end
         end
      end

      if (take_rd) begin
         if (n_c == '0) begin
            out_load           = 1'b1;
            out_in.kind        = KIND_READ_EMPTY;
            out_in.last        = 1'b1;
         end else begin
            occ_in      = occ_ff - CW'(n_c);
            rd_left_in  = n_c;
            rd_total_in = n_c;
         end
      end

      if (take_clr) begin
         wr_pos_in  = '0;
         rd_pos_in  = '0;
         occ_in     = '0;
         left_in    = '0;
         adm_in     = 1'b0;
         total_in   = '0;
         msg_pos_in = '0;
      end

      if (cmd.fetch) begin
         rd_left_in = rd_left_ff - 1'b1;
         rd_pos_in  = advance(rd_pos_ff, size_c);
      end

      if (cmd.send) begin
         out_load        = 1'b1;
         out_in.kind     = KIND_READ_BYTE;
         out_in.data_out = rdata_ff;
         out_in.last     = (rd_left_ff == '0);
         if (rd_left_ff == '0) begin
            out_in.removed_count = rd_total_ff;
         end
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Byte store: one write port for message bytes, one read port for reads.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pos_e] <= req_payload.data_in;
      end
      if (cmd.fetch) begin
         rdata_ff <= mem[rd_pos_ff];
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= CW'(DEPTH);
         drain_mode_ff  <= 1'b0;
         wr_pos_ff      <= '0;
         rd_pos_ff      <= '0;
         occ_ff         <= '0;
         left_ff        <= '0;
         total_ff       <= '0;
         adm_ff         <= 1'b0;
         msg_pos_ff     <= '0;
         rd_left_ff     <= '0;
         rd_total_ff    <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_BUFFER_SIZE: buffer_size_ff <= CW'(csr_wdata);
               CSR_DRAIN_MODE:  drain_mode_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         occ_ff       <= occ_in;
         left_ff      <= left_in;
         total_ff     <= total_in;
         adm_ff       <= adm_in;
         msg_pos_ff   <= msg_pos_in;
         rd_left_ff   <= rd_left_in;
         rd_total_ff  <= rd_total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_payload     = out_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.read_go  = (req_payload.op == OP_READ) && (n_c != '0);
   assign status.rd_more  = (rd_left_ff != '0);

endmodule

FILE: hw/rtl/byte_ring_buffer_message_admit_top.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with whole-message admission
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one item per handshake: a message byte, a read
// request or a clear. The first byte of a message carries its length; the
// message is stored only if the free space covers it, and its last byte
// yields one rsp_ item with the accepted count (zero when dropped).
// Write bytes stream in at one per cycle while the output register is free
// or being emptied.
// A read request is accepted, the FETCH state reads its first byte from the
// single registered read port of the byte store, and the SEND state then
// delivers one byte item per cycle while the output register is free. A read
// that finds nothing gives one item in the cycle after acceptance.
// The csr_ channel writes buffer_size (index 0), drain_mode (index 1), is
// always ready; the user must write it only while the block is idle, unchecked.
// Reset empties the ring and restores the configuration; the byte store
// itself is not cleared.
// When rsp_ready is low the pending result holds in the output register
// and no further item is accepted until it is taken.
// ----------------------------------------------------------------------------
module byte_ring_buffer_message_admit_top
   import brma_pkg::*;
#(
   parameter int DEPTH    = 4096,
   parameter int MAX_READ = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Configuration writes are taken in any cycle.
   assign csr_ready = 1'b1;

   brma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brma_dpath #(
      .DEPTH    (DEPTH),
      .MAX_READ (MAX_READ)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
